FILE: rtl/core/cbs_pkg.sv
// Shared types and codes for the character boundary segmenter.
`default_nettype none

package cbs_pkg;

    // Encoding selected by the mode register.
    localparam logic MODE_UTF8    = 1'b0;
    localparam logic MODE_GB18030 = 1'b1;

    // Outcome of checking the bytes gathered so far.
    localparam logic [1:0] ST_BAD  = 2'd0;
    localparam logic [1:0] ST_MORE = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    // Result of the sequence check handed to the top level.
    typedef struct packed {
        logic [1:0] status;
        logic [2:0] char_len;
    } check_t;

endpackage

`default_nettype wire

FILE: rtl/core/char_boundary_segmenter_top.sv
// Top level of the character boundary segmenter: input stage, state and result stage.
`default_nettype none

//  Channel  | Signals                                          | Direction
//  ---------+--------------------------------------------------+----------
//  input    | in_valid, in_ready, in_byte, end_of_text         | in
//  result   | out_valid, out_ready, char_data, char_len,       | out
//           | is_error, text_done                              |
//  config   | cfg_wr_en, cfg_wr_data (encoding mode)           | in
//
// One byte is taken per cycle while the result side is not stalled; each byte waits in the input register
// and its result, if any, is loaded into the result register as the byte leaves it.
// The character state updates in that same step, so bytes follow back to back.
// A stalled result holds the input register; the input side then stalls too.
// Reset clears the control state, the partial character and the mode register.

module char_boundary_segmenter_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_wr_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  in_byte,
    input  wire logic        end_of_text,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      char_data,
    output logic [2:0]       char_len,
    output logic             is_error,
    output logic             text_done
);
    import cbs_pkg::*;

    logic        mode_reg;
    logic        in_valid_reg;
    logic [7:0]  byte_reg;
    logic        eot_reg;
    logic [23:0] partial_reg, partial_next;
    logic [1:0]  seen_reg, seen_next;
    logic        dropping_reg, dropping_next;
    logic        out_valid_reg;
    logic [31:0] data_reg, data_next;
    logic [2:0]  len_reg, len_next;
    logic        error_reg, error_next;
    logic        done_reg, done_next;
    logic        emit;
    logic        advance;
    logic [31:0] gathered;
    logic [31:0] aligned;
    logic [2:0]  count;
    check_t      chk;

    // Mode register; the user must write it only while the block is idle, which the block itself does not enforce.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_UTF8;
        end
        else if (cfg_wr_en)
        begin
            mode_reg <= cfg_wr_data;
        end
    end

    // The held byte moves on when the result register is free or being emptied.
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= in_byte;
            eot_reg  <= end_of_text;
        end
    end

    // Join the held bytes with the new one and left-align them for the check.
    assign gathered = {partial_reg, byte_reg};
    assign count    = {1'b0, seen_reg} + 3'd1;

    always_comb
    begin
        unique case (seen_reg)
            2'd0:    aligned = {gathered[7:0], 24'd0};
            2'd1:    aligned = {gathered[15:0], 16'd0};
            2'd2:    aligned = {gathered[23:0], 8'd0};
            default: aligned = gathered;
        endcase
    end

    cbs_check u_check (
        .mode      (mode_reg),
        .seq_bytes (aligned),
        .seq_count (count),
        .result    (chk)
    );

    // Next character state and the result for the byte in the input register.
    always_comb
    begin
        partial_next  = partial_reg;
        seen_next     = seen_reg;
        dropping_next = dropping_reg;
        emit          = 1'b0;
        data_next     = 32'd0;
        len_next      = 3'd0;
        error_next    = 1'b0;
        done_next     = eot_reg;

        if (dropping_reg)
        begin
            // Skip the rest of a failed text; its end gives the end marker.
            if (eot_reg)
            begin
                emit          = 1'b1;
                dropping_next = 1'b0;
                partial_next  = 24'd0;
                seen_next     = 2'd0;
            end
        end
        else if (chk.status == ST_DONE)
        begin
            emit         = 1'b1;
            data_next    = gathered;
            len_next     = chk.char_len;
            partial_next = 24'd0;
            seen_next    = 2'd0;
        end
        else if (chk.status == ST_MORE && !eot_reg)
        begin
            partial_next = gathered[23:0];
            seen_next    = count[1:0];
        end
        else
        begin
            // Invalid byte, or the text ended inside a character.
            emit          = 1'b1;
            error_next    = 1'b1;
            partial_next  = 24'd0;
            seen_next     = 2'd0;
            dropping_next = !eot_reg;
        end
    end

    // Character state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg  <= 24'd0;
            seen_reg     <= 2'd0;
            dropping_reg <= 1'b0;
        end
        else if (advance)
        begin
            partial_reg  <= partial_next;
            seen_reg     <= seen_next;
            dropping_reg <= dropping_next;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= emit;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            data_reg  <= data_next;
            len_reg   <= len_next;
            error_reg <= error_next;
            done_reg  <= done_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign char_data = data_reg;
    assign char_len  = len_reg;
    assign is_error  = error_reg;
    assign text_done = done_reg;

    // While dropping, no partial character may be held.
    a_drop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        dropping_reg |-> (seen_reg == 2'd0 && partial_reg == 24'd0))
        else $error("partial character held while dropping");

    // An error transaction carries no character.
    a_error_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && is_error) |-> (char_len == 3'd0 && char_data == 32'd0))
        else $error("error result carries character bytes");

    // A result without a character and without an error is the end marker.
    a_marker_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !is_error && char_len == 3'd0) |-> text_done)
        else $error("empty result that is not an end marker");

    // A stalled input side means a byte is waiting behind a stalled result.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (in_valid_reg && out_valid_reg && !out_ready))
        else $error("input stalled without a stalled result");

endmodule

`default_nettype wire

FILE: rtl/core/cbs_check.sv
// Combinational UTF-8 and GB18030 sequence check over up to four bytes.
`default_nettype none

module cbs_check (
    input  wire logic          mode,
    input  wire logic [31:0]   seq_bytes,
    input  wire logic [2:0]    seq_count,
    output cbs_pkg::check_t    result
);
    import cbs_pkg::*;

    localparam logic [7:0] B_ASCII_TOP = 8'h80;
    localparam logic [7:0] B_C2        = 8'hC2;
    localparam logic [7:0] B_E0        = 8'hE0;
    localparam logic [7:0] B_A0        = 8'hA0;
    localparam logic [7:0] B_F0        = 8'hF0;
    localparam logic [7:0] B_F4        = 8'hF4;
    localparam logic [7:0] B_90        = 8'h90;
    localparam logic [7:0] B_81        = 8'h81;
    localparam logic [7:0] B_FE        = 8'hFE;
    localparam logic [7:0] B_40        = 8'h40;
    localparam logic [7:0] B_7F        = 8'h7F;
    localparam logic [7:0] B_30        = 8'h30;
    localparam logic [7:0] B_39        = 8'h39;

    logic [7:0] b0, b1, b2, b3;
    logic       u_lead_ok, u_cont_ok, u_special_bad;
    logic [2:0] u_len;
    check_t     u_res;
    logic       g_b1_two, g_b1_four, g_b2_ok, g_b3_ok;
    check_t     g_res;

    // Bytes arrive left-aligned, earliest byte in the top lane.
    assign b0 = seq_bytes[31:24];
    assign b1 = seq_bytes[23:16];
    assign b2 = seq_bytes[15:8];
    assign b3 = seq_bytes[7:0];

    // UTF-8: length from the lead byte, then continuation and overlong checks.
    always_comb
    begin
        u_lead_ok = 1'b1;
        u_len     = 3'd1;
        priority if (b0 < B_ASCII_TOP)
        begin
            u_len = 3'd1;
        end
        else if (b0 >= B_C2 && b0 < B_E0)
        begin
            u_len = 3'd2;
        end
        else if (b0[7:4] == 4'hE)
        begin
            u_len = 3'd3;
        end
        else if (b0[7:3] == 5'b11110 && b0 <= B_F4)
        begin
            u_len = 3'd4;
        end
        else
        begin
            u_lead_ok = 1'b0;
        end

        u_cont_ok = (seq_count < 3'd2 || b1[7:6] == 2'b10)
                 && (seq_count < 3'd3 || b2[7:6] == 2'b10)
                 && (seq_count < 3'd4 || b3[7:6] == 2'b10);

        u_special_bad = (seq_count >= 3'd2)
                     && ((b0 == B_E0 && b1 < B_A0) || (b0 == B_F0 && b1 < B_90));

        u_res.char_len = u_len;
        priority if (!u_lead_ok || seq_count > u_len || !u_cont_ok || u_special_bad)
        begin
            u_res.status = ST_BAD;
        end
        else if (seq_count == u_len)
        begin
            u_res.status = ST_DONE;
        end
        else
        begin
            u_res.status = ST_MORE;
        end
    end

    // GB18030: single byte, two-byte, or four-byte forms decided by the second byte.
    always_comb
    begin
        g_b1_two  = (b1 >= B_40) && (b1 <= B_FE) && (b1 != B_7F);
        g_b1_four = (b1 >= B_30) && (b1 <= B_39);
        g_b2_ok   = (b2 >= B_81) && (b2 <= B_FE);
        g_b3_ok   = (b3 >= B_30) && (b3 <= B_39);

        g_res.char_len = 3'd0;
        priority if (b0 < B_ASCII_TOP)
        begin
            g_res.char_len = 3'd1;
            g_res.status   = (seq_count == 3'd1) ? ST_DONE : ST_BAD;
        end
        else if (b0 < B_81 || b0 > B_FE)
        begin
            g_res.status = ST_BAD;
        end
        else if (seq_count == 3'd1)
        begin
            g_res.status = ST_MORE;
        end
        else if (g_b1_two)
        begin
            g_res.char_len = 3'd2;
            g_res.status   = (seq_count == 3'd2) ? ST_DONE : ST_BAD;
        end
        else if (g_b1_four)
        begin
            g_res.char_len = 3'd4;
            priority if ((seq_count >= 3'd3 && !g_b2_ok) || (seq_count >= 3'd4 && !g_b3_ok))
            begin
                g_res.status = ST_BAD;
            end
            else if (seq_count == 3'd4)
            begin
                g_res.status = ST_DONE;
            end
            else
            begin
                g_res.status = ST_MORE;
            end
        end
        else
        begin
            g_res.status = ST_BAD;
        end
    end

    assign result = (mode == MODE_GB18030) ? g_res : u_res;

endmodule

`default_nettype wire

FILE: test/char_boundary_segmenter_top_tb.sv
// Self-checking testbench for the character boundary segmenter under UTF-8 and GB18030 rules.
`default_nettype none

module char_boundary_segmenter_top_tb;

    import cbs_pkg::*;

    // One result transaction as it leaves the block.
    typedef struct packed {
        logic [31:0] data;
        logic [2:0]  len;
        logic        err;
        logic        done;
    } seg_result_t;

    // Tracks the character being gathered and queues the results that each byte should give.
    class segment_scoreboard;
        logic        mode;
        logic [23:0] held;
        logic [1:0]  held_cnt;
        logic        dropping;
        seg_result_t expected_q[$];
        int          errors;

        function new();
            mode     = MODE_UTF8;
            held     = '0;
            held_cnt = '0;
            dropping = 1'b0;
            errors   = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Adds one expected result at the back of the queue.
        function void queue_result(seg_result_t r);
            expected_q = {expected_q, r};
        endfunction

        // Judges n gathered bytes under UTF-8 rules.
        function logic [1:0] utf8_status(logic [7:0] s[4], int n);
            logic [7:0] lead;
            int         want;
            lead = s[0];
            if (lead < 8'h80)
                want = 1;
            else if (lead >= 8'hC2 && lead < 8'hE0)
                want = 2;
            else if (lead[7:4] == 4'hE)
                want = 3;
            else if (lead[7:3] == 5'b11110 && lead <= 8'hF4)
                want = 4;
            else
                return ST_BAD;
            if (n > want)
                return ST_BAD;
            for (int i = 1; i < n; i++)
                if (s[i][7:6] != 2'b10)
                    return ST_BAD;
            // Overlong three- and four-byte forms are refused.
            if (n >= 2 && lead == 8'hE0 && s[1] < 8'hA0)
                return ST_BAD;
            if (n >= 2 && lead == 8'hF0 && s[1] < 8'h90)
                return ST_BAD;
            return (n == want) ? ST_DONE : ST_MORE;
        endfunction

        // Judges n gathered bytes under GB18030 rules.
        function logic [1:0] gb_status(logic [7:0] s[4], int n);
            int want;
            if (s[0] < 8'h80)
                return (n == 1) ? ST_DONE : ST_BAD;
            if (s[0] < 8'h81 || s[0] == 8'hFF)
                return ST_BAD;
            if (n == 1)
                return ST_MORE;
            if (s[1] >= 8'h40 && s[1] != 8'h7F && s[1] != 8'hFF)
                want = 2;
            else if (s[1] >= 8'h30 && s[1] <= 8'h39)
                want = 4;
            else
                return ST_BAD;
            if (n > want)
                return ST_BAD;
            if (n >= 3 && (s[2] < 8'h81 || s[2] == 8'hFF))
                return ST_BAD;
            if (n >= 4 && (s[3] < 8'h30 || s[3] > 8'h39))
                return ST_BAD;
            return (n == want) ? ST_DONE : ST_MORE;
        endfunction

        // Called for every accepted input transaction.
        function void note_input(logic [7:0] b, logic eot);
            logic [7:0]  seq[4];
            int          n;
            logic [1:0]  st;
            logic [31:0] joined;
            seg_result_t r;
            r = '0;
            // After an error only the end of the text gives anything: the end marker.
            if (dropping) begin
                if (eot) begin
                    dropping = 1'b0;
                    r.done   = 1'b1;
                    queue_result(r);
                end
                return;
            end
            n = held_cnt + 1;
            for (int i = 0; i < 4; i++)
                seq[i] = '0;
            for (int i = 0; i < n - 1; i++)
                seq[i] = held[8 * (n - 2 - i) +: 8];
            seq[n - 1] = b;
            // Held bytes are judged again under whatever mode is now in force.
            st     = (mode == MODE_GB18030) ? gb_status(seq, n) : utf8_status(seq, n);
            joined = {held, b};
            if (st == ST_DONE) begin
                r.data = joined;
                r.len  = 3'(n);
                r.done = eot;
                queue_result(r);
                held     = '0;
                held_cnt = '0;
            end
            else if (st == ST_MORE && !eot) begin
                held     = joined[23:0];
                held_cnt = 2'(n);
            end
            else begin
                // Invalid byte, or the text ended part way through a character.
                r.err = 1'b1;
                r.done = eot;
                queue_result(r);
                held     = '0;
                held_cnt = '0;
                dropping = !eot;
            end
        endfunction

        // Called for every accepted result transaction.
        function void check_result(seg_result_t got);
            seg_result_t exp_r;
            if (expected_q.size() == 0) begin
                $error("unexpected result: char_data %h char_len %0d is_error %b text_done %b",
                       got.data, got.len, got.err, got.done);
                errors++;
                return;
            end
            exp_r = expected_q.pop_front();
            if (got.data !== exp_r.data) begin
                $error("char_data: expected %h, actual %h", exp_r.data, got.data);
                errors++;
            end
            if (got.len !== exp_r.len) begin
                $error("char_len: expected %0d, actual %0d", exp_r.len, got.len);
                errors++;
            end
            if (got.err !== exp_r.err) begin
                $error("is_error: expected %b, actual %b", exp_r.err, got.err);
                errors++;
            end
            if (got.done !== exp_r.done) begin
                $error("text_done: expected %b, actual %b", exp_r.done, got.done);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic        cfg_wr_data;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  in_byte;
    logic        end_of_text;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] char_data;
    logic [2:0]  char_len;
    logic        is_error;
    logic        text_done;

    segment_scoreboard sb = new();

    logic [7:0] text_q[$];
    int         items_sent  = 0;
    int         burst_left  = 10;
    int         ready_cnt   = 0;
    int         ready_style = 0;

    char_boundary_segmenter_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_byte     (in_byte),
        .end_of_text (end_of_text),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .char_data   (char_data),
        .char_len    (char_len),
        .is_error    (is_error),
        .text_done   (text_done)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #5000000;
        $display("simulation failed");
        $finish;
    end

    // The receiver switches at random between four stall styles.
    always @(posedge clk)
    begin
        ready_cnt <= ready_cnt + 1;
        if (ready_cnt % 50 == 0)
            ready_style <= $urandom_range(3, 0);
        case (ready_style)
            0:       out_ready <= 1'b1;
            1:       out_ready <= 1'($urandom_range(1, 0));
            2:       out_ready <= (ready_cnt % 4 == 0);
            default: out_ready <= ($urandom_range(9, 0) != 0);
        endcase
    end

    // Observe both channels at each edge.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (in_valid && in_ready === 1'b1)
                sb.note_input(in_byte, end_of_text);
            if (out_valid === 1'b1 && out_ready)
                sb.check_result(seg_result_t'({char_data, char_len, is_error, text_done}));
        end
    end

    function logic [7:0] pick(int hi, int lo);
        return 8'($urandom_range(hi, lo));
    endfunction

    // Adds one byte at the end of the text being built.
    function void append_byte(logic [7:0] b);
        text_q = {text_q, b};
    endfunction

    // Appends one well-formed character for the given mode; min_kind 1 forces a multi-byte one.
    function void add_char(logic m, int min_kind);
        int         kind;
        logic [7:0] lead;
        kind = $urandom_range(3, min_kind);
        if (m == MODE_UTF8) begin
            case (kind)
                0: append_byte(pick(8'h7F, 8'h00));
                1: begin
                    append_byte(pick(8'hDF, 8'hC2));
                    append_byte(pick(8'hBF, 8'h80));
                end
                2: begin
                    lead = pick(8'hEF, 8'hE0);
                    append_byte(lead);
                    append_byte(lead == 8'hE0 ? pick(8'hBF, 8'hA0) : pick(8'hBF, 8'h80));
                    append_byte(pick(8'hBF, 8'h80));
                end
                default: begin
                    lead = pick(8'hF4, 8'hF0);
                    append_byte(lead);
                    append_byte(lead == 8'hF0 ? pick(8'hBF, 8'h90) : pick(8'hBF, 8'h80));
                    append_byte(pick(8'hBF, 8'h80));
                    append_byte(pick(8'hBF, 8'h80));
                end
            endcase
        end
        else begin
            case (kind)
                0: append_byte(pick(8'h7F, 8'h00));
                1, 2: begin
                    append_byte(pick(8'hFE, 8'h81));
                    lead = pick(8'hFE, 8'h40);
                    append_byte(lead == 8'h7F ? 8'h80 : lead);
                end
                default: begin
                    append_byte(pick(8'hFE, 8'h81));
                    append_byte(pick(8'h39, 8'h30));
                    append_byte(pick(8'hFE, 8'h81));
                    append_byte(pick(8'h39, 8'h30));
                end
            endcase
        end
    endfunction

    // Offers one byte and waits for its transaction; the sender rests between bursts.
    task automatic feed(logic [7:0] b, logic eot);
        in_valid    <= 1'b1;
        in_byte     <= b;
        end_of_text <= eot;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        burst_left--;
        if (burst_left <= 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(8, 1)) @(posedge clk);
            burst_left = $urandom_range(40, 1);
        end
    endtask

    // Sends the queued bytes; bytes past index mark are expected to be dropped and go uncounted.
    task automatic play_text(logic ends, int mark);
        for (int i = 0; i < text_q.size(); i++) begin
            feed(text_q[i], ends && (i == text_q.size() - 1));
            if (i <= mark)
                items_sent++;
        end
    endtask

    // Holds the sender off until every expected result has come and the pipeline is empty.
    task automatic drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_mode(logic m);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= m;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sb.mode = m;
    endtask

    // One random text: mostly well formed, sometimes corrupted, truncated or pure noise.
    task automatic run_text();
        int pos;
        int mark;
        text_q.delete();
        repeat ($urandom_range(8, 1)) add_char(sb.mode, 0);
        mark = text_q.size();
        case ($urandom_range(9, 0))
            0: begin
                pos = $urandom_range(text_q.size() - 1, 0);
                text_q[pos] = pick(8'hFF, 8'h00);
                mark = pos;
            end
            1: begin
                add_char(sb.mode, 1);
                void'(text_q.pop_back());
            end
            2: begin
                text_q.delete();
                repeat ($urandom_range(6, 1)) append_byte(pick(8'hFF, 8'h00));
                mark = 0;
            end
            default: ;
        endcase
        play_text(1'b1, mark);
    endtask

    initial
    begin
        rst_n       <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= 1'b0;
        in_valid    <= 1'b0;
        in_byte     <= 8'h00;
        end_of_text <= 1'b0;
        out_ready   <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // UTF-8 extremes: ASCII, smallest three-byte form, a surrogate, the top four-byte lead.
        text_q = '{8'h00, 8'hE0, 8'hA0, 8'h80, 8'hED, 8'hA0, 8'h80, 8'hF4, 8'hBF, 8'hBF, 8'hBF};
        play_text(1'b1, text_q.size());
        // Overlong form gives an error; the rest is dropped and the end gives a marker.
        text_q = '{8'hE0, 8'h80, 8'hFF, 8'h41};
        play_text(1'b1, 1);
        // Text ending part way through a four-byte character.
        text_q = '{8'hF0, 8'h90};
        play_text(1'b1, text_q.size());
        // Mode switched while a character is half gathered.
        text_q = '{8'hE4};
        play_text(1'b0, text_q.size());
        set_mode(MODE_GB18030);
        text_q = '{8'h35, 8'h81, 8'h30};
        play_text(1'b1, text_q.size());
        // GB18030 two-byte extremes, then an invalid lead on the last byte.
        text_q = '{8'h81, 8'h40, 8'hFE, 8'hFE, 8'h80};
        play_text(1'b1, text_q.size());

        // Random phases, alternating the mode, sometimes leaving a character open across the switch.
        for (int phase = 0; phase < 8; phase++) begin
            set_mode((phase % 2 == 1) ? MODE_GB18030 : MODE_UTF8);
            while (items_sent < (phase + 1) * 82) begin
                run_text();
                if ($urandom_range(19, 0) == 0)
                    drain();
            end
            if ($urandom_range(1, 0) == 1) begin
                text_q.delete();
                add_char(sb.mode, 1);
                void'(text_q.pop_back());
                play_text(1'b0, text_q.size());
            end
        end
        text_q = '{8'h41};
        play_text(1'b1, 0);

        drain();
        if (sb.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire

FILE: char_boundary_segmenter_top.f
rtl/core/cbs_pkg.sv
rtl/core/cbs_check.sv
rtl/core/char_boundary_segmenter_top.sv
test/char_boundary_segmenter_top_tb.sv
